/* hw/rtl/sts_pkg.sv */
// shared constants, vertex type and width helpers for the triangle span pipeline
`default_nettype none

package sts_pkg;

    // fixed field widths of the stream payload
    localparam int COORD_W = 16;
    localparam int ROW_W   = 12;
    localparam int SPAN_W  = 12;

    // rounded row of a vertex, wide enough for any coordinate and fraction setting
    localparam int RROW_W = COORD_W + 1;

    localparam int FRAC_BITS_DEF = 4;
    localparam int INT_BITS_DEF  = 12;

    localparam int S_FIELDS_W = 6 * COORD_W + ROW_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ROW_W + 2 * SPAN_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_vtx;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // row position minus vertex y, at fixed-point scale
    function automatic int dyr_w(input int frac);
        return max_int(ROW_W + frac, COORD_W) + 1;
    endfunction

    // signed numerator of the edge interpolation
    function automatic int num_w(input int frac);
        return max_int(2 * COORD_W + 1, COORD_W + 1 + dyr_w(frac)) + 1;
    endfunction

    // magnitude of the denominator |dy| scaled by the fraction
    function automatic int den_w(input int frac);
        return COORD_W + 1 + frac;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/scanline_triangle_span.sv */
// top level of the scanline triangle span pipeline
`default_nettype none

// channel    dir  signals                      transaction contents
// s_axis     in   i_s_tvalid/o_s_tready        v0_x v0_y v1_x v1_y v2_x v2_y row
// m_axis     out  o_m_tvalid/i_m_tready        row_out span_left span_right, row_covered
//
// INT_BITS + 7 register stages (order, edge setup, dividers, output), one
// transaction per cycle sustained while the output is taken; the depth comes
// from the two dividers, which resolve one quotient bit per stage after an
// overflow stage
// synchronous active-low reset clears only the per-stage valid bits
// each stage moves on when it is empty or the stage after it moves, so bubbles
// close up and input is taken while a finished span waits at the output

module scanline_triangle_span #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = sts_pkg::INT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y (16 each), row (12), zero pad
    input  logic [sts_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // row_out, span_left, span_right (12 each), zero pad
    output logic [sts_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // row_covered
    output logic                            o_m_tuser
);

    localparam int XW   = sts_pkg::COORD_W;
    localparam int RW   = sts_pkg::ROW_W;
    localparam int SW   = sts_pkg::SPAN_W;
    localparam int RRW  = sts_pkg::RROW_W;
    localparam int NMW  = sts_pkg::num_w(FRAC_BITS);
    localparam int DENW = sts_pkg::den_w(FRAC_BITS);
    localparam int QB   = INT_BITS;
    localparam int VW   = INT_BITS + 1;
    localparam int PADW = sts_pkg::M_TDATA_W - RW - 2 * SW;

    // stage map: 0..1 order, 2..4 edge setup, 5..5+QB dividers, last is output
    localparam int ST_DIV = 5;
    localparam int NST    = QB + 7;

    localparam logic signed [VW-1:0] SPAN_HI = VW'((1 << (QB - 1)) - 1);
    localparam logic signed [VW-1:0] SPAN_LO = -VW'(1 << (QB - 1));
    localparam logic [QB-1:0]        MAG_HI  = QB'((1 << (QB - 1)) - 1);
    localparam logic [QB-1:0]        MAG_LO  = QB'(1 << (QB - 1));

    typedef struct packed {
        logic [RW-1:0] row;
        logic          cov;
    } t_side;

    // pipeline control
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] w_adv;

    // unpacked input transaction
    sts_pkg::t_vtx w_v0;
    sts_pkg::t_vtx w_v1;
    sts_pkg::t_vtx w_v2;
    logic [RW-1:0] w_row;

    // order stage outputs
    sts_pkg::t_vtx          w_va;
    sts_pkg::t_vtx          w_vb;
    sts_pkg::t_vtx          w_vc;
    logic signed [RRW-1:0]  w_top;
    logic signed [RRW-1:0]  w_mid;
    logic signed [RRW-1:0]  w_bot;
    logic [RW-1:0]          w_row_o;

    // edge stage outputs, lane 0 short edge, lane 1 long edge
    logic [NMW-1:0]  w_num [2];
    logic [DENW-1:0] w_den [2];
    logic            w_neg [2];
    logic            w_cov_e;
    logic [RW-1:0]   w_row_e;

    // divider outputs
    logic [QB-1:0] w_q [2];
    logic          w_sat [2];
    logic          w_qneg [2];

    // row and coverage travel alongside the dividers
    t_side r_side [QB+1];
    t_side w_side_src [QB+1];

    // output stage
    logic signed [VW-1:0] w_xa;
    logic signed [VW-1:0] w_xb;
    logic signed [VW-1:0] w_lo;
    logic signed [VW-1:0] w_hi;
    logic [RW-1:0]        r_row_o;
    logic [SW-1:0]        r_span_l;
    logic [SW-1:0]        r_span_r;
    logic                 r_cov_o;

    // sign and clamp of a divider result into the signed span range
    function automatic logic signed [VW-1:0] fix_span(
        input logic [QB-1:0] q,
        input logic          sat,
        input logic          neg
    );
        logic signed [VW-1:0] qe;
        qe = $signed({1'b0, q});
        if (neg) begin
            if (sat || (q > MAG_LO)) begin
                return SPAN_LO;
            end
            return -qe;
        end
        if (sat || (q > MAG_HI)) begin
            return SPAN_HI;
        end
        return qe;
    endfunction

    // a stage advances when it or any stage after it holds a bubble,
    // or the output transaction is taken
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            w_adv[k] = i_m_tready || (((~r_vld) >> k) != '0);
        end
    end

    assign n_vld      = {r_vld[NST-2:0], i_s_tvalid};
    assign o_s_tready = w_adv[0];
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // input field unpacking, first field in the lowest bits
    assign w_v0.x = i_s_tdata[0 * XW +: XW];
    assign w_v0.y = i_s_tdata[1 * XW +: XW];
    assign w_v1.x = i_s_tdata[2 * XW +: XW];
    assign w_v1.y = i_s_tdata[3 * XW +: XW];
    assign w_v2.x = i_s_tdata[4 * XW +: XW];
    assign w_v2.y = i_s_tdata[5 * XW +: XW];
    assign w_row  = i_s_tdata[6 * XW +: RW];

    sts_order #(
        .FRAC_BITS (FRAC_BITS)
    ) u_order (
        .i_clk  (i_clk),
        .i_adv  (w_adv[1:0]),
        .i_v0   (w_v0),
        .i_v1   (w_v1),
        .i_v2   (w_v2),
        .i_row  (w_row),
        .o_va   (w_va),
        .o_vb   (w_vb),
        .o_vc   (w_vc),
        .o_top  (w_top),
        .o_mid  (w_mid),
        .o_bot  (w_bot),
        .o_row  (w_row_o)
    );

    sts_edge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_edge (
        .i_clk  (i_clk),
        .i_adv  (w_adv[4:2]),
        .i_va   (w_va),
        .i_vb   (w_vb),
        .i_vc   (w_vc),
        .i_top  (w_top),
        .i_mid  (w_mid),
        .i_bot  (w_bot),
        .i_row  (w_row_o),
        .o_num  (w_num),
        .o_den  (w_den),
        .o_neg  (w_neg),
        .o_cov  (w_cov_e),
        .o_row  (w_row_e)
    );

    sts_div #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_div_short (
        .i_clk  (i_clk),
        .i_adv  (w_adv[ST_DIV + QB:ST_DIV]),
        .i_num  (w_num[0]),
        .i_den  (w_den[0]),
        .i_neg  (w_neg[0]),
        .o_q    (w_q[0]),
        .o_sat  (w_sat[0]),
        .o_neg  (w_qneg[0])
    );

    sts_div #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_div_long (
        .i_clk  (i_clk),
        .i_adv  (w_adv[ST_DIV + QB:ST_DIV]),
        .i_num  (w_num[1]),
        .i_den  (w_den[1]),
        .i_neg  (w_neg[1]),
        .o_q    (w_q[1]),
        .o_sat  (w_sat[1]),
        .o_neg  (w_qneg[1])
    );

    // side line kept in step with the divider stages
    always_comb begin
        w_side_src[0].row = w_row_e;
        w_side_src[0].cov = w_cov_e;
        for (int j = 1; j <= QB; j++) begin
            w_side_src[j] = r_side[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= QB; j++) begin
            if (w_adv[ST_DIV + j]) begin
                r_side[j] <= w_side_src[j];
            end
        end
    end

    // clamp both ends, order them, zero the span of an uncovered row
    always_comb begin
        w_xa = fix_span(w_q[0], w_sat[0], w_qneg[0]);
        w_xb = fix_span(w_q[1], w_sat[1], w_qneg[1]);
        w_lo = (w_xa > w_xb) ? w_xb : w_xa;
        w_hi = (w_xa > w_xb) ? w_xa : w_xb;
        if (!r_side[QB].cov) begin
            w_lo = '0;
            w_hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_row_o  <= r_side[QB].row;
            r_span_l <= SW'(w_lo);
            r_span_r <= SW'(w_hi);
            r_cov_o  <= r_side[QB].cov;
        end
    end

    assign o_m_tdata = {{PADW{1'b0}}, r_span_r, r_span_l, r_row_o};
    assign o_m_tuser = r_cov_o;

    // input is refused only with every stage full and the output held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> ((&r_vld) && !i_m_tready))
        else $error("input refused while the pipeline has room");

    // a held output must not block input while a bubble remains upstream
    a_bubble_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && !(&r_vld[NST-2:0])) |-> o_s_tready)
        else $error("bubble not closed behind a held output");

    // an accepted transaction occupies the first stage next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transaction lost at entry");

    // an uncovered row carries an empty span
    a_uncov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_cov_o) |-> ((r_span_l == '0) && (r_span_r == '0)))
        else $error("uncovered row with non-zero span");

endmodule

`default_nettype wire

/* hw/rtl/sts_order.sv */
// vertex sort by y and rounding of the three vertex rows, two register stages
`default_nettype none

module sts_order #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic [1:0]                         i_adv,
    input  sts_pkg::t_vtx                      i_v0,
    input  sts_pkg::t_vtx                      i_v1,
    input  sts_pkg::t_vtx                      i_v2,
    input  logic [sts_pkg::ROW_W-1:0]          i_row,
    output sts_pkg::t_vtx                      o_va,
    output sts_pkg::t_vtx                      o_vb,
    output sts_pkg::t_vtx                      o_vc,
    output logic signed [sts_pkg::RROW_W-1:0]  o_top,
    output logic signed [sts_pkg::RROW_W-1:0]  o_mid,
    output logic signed [sts_pkg::RROW_W-1:0]  o_bot,
    output logic [sts_pkg::ROW_W-1:0]          o_row
);

    localparam int XW  = sts_pkg::COORD_W;
    localparam int RRW = sts_pkg::RROW_W;
    localparam logic signed [RRW-1:0] RMASK = RRW'((1 << (FRAC_BITS + 1)) - 1);

    sts_pkg::t_vtx w_a;
    sts_pkg::t_vtx w_b;
    sts_pkg::t_vtx w_c;
    sts_pkg::t_vtx w_t;

    sts_pkg::t_vtx r_a0;
    sts_pkg::t_vtx r_b0;
    sts_pkg::t_vtx r_c0;
    logic [sts_pkg::ROW_W-1:0] r_row0;

    // trunc toward zero of (2y+1) / 2^(frac+1)
    function automatic logic signed [RRW-1:0] round_row(input logic [XW-1:0] y);
        logic signed [RRW-1:0] t;
        logic signed [RRW-1:0] b;
        t = $signed({y, 1'b1});
        b = t + (t[RRW-1] ? RMASK : RRW'(0));
        return b >>> (FRAC_BITS + 1);
    endfunction

    // three compare-and-swaps, strict less-than, whole vertex moves
    always_comb begin
        w_a = i_v0;
        w_b = i_v1;
        w_c = i_v2;
        w_t = w_a;
        if ($signed(w_b.y) < $signed(w_a.y)) begin
            w_t = w_a;
            w_a = w_b;
            w_b = w_t;
        end
        if ($signed(w_c.y) < $signed(w_a.y)) begin
            w_t = w_a;
            w_a = w_c;
            w_c = w_t;
        end
        if ($signed(w_c.y) < $signed(w_b.y)) begin
            w_t = w_b;
            w_b = w_c;
            w_c = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_a0   <= w_a;
            r_b0   <= w_b;
            r_c0   <= w_c;
            r_row0 <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            o_va  <= r_a0;
            o_vb  <= r_b0;
            o_vc  <= r_c0;
            o_top <= round_row(r_a0.y);
            o_mid <= round_row(r_b0.y);
            o_bot <= round_row(r_c0.y);
            o_row <= r_row0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sts_edge.sv */
// coverage test, edge selection and interpolation numerator/denominator, three stages
`default_nettype none

module sts_edge #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic [2:0]                                  i_adv,
    input  sts_pkg::t_vtx                               i_va,
    input  sts_pkg::t_vtx                               i_vb,
    input  sts_pkg::t_vtx                               i_vc,
    input  logic signed [sts_pkg::RROW_W-1:0]           i_top,
    input  logic signed [sts_pkg::RROW_W-1:0]           i_mid,
    input  logic signed [sts_pkg::RROW_W-1:0]           i_bot,
    input  logic [sts_pkg::ROW_W-1:0]                   i_row,
    output logic [sts_pkg::num_w(FRAC_BITS)-1:0]        o_num [2],
    output logic [sts_pkg::den_w(FRAC_BITS)-1:0]        o_den [2],
    output logic                                        o_neg [2],
    output logic                                        o_cov,
    output logic [sts_pkg::ROW_W-1:0]                   o_row
);

    localparam int XW   = sts_pkg::COORD_W;
    localparam int DYW  = XW + 1;
    localparam int RW   = sts_pkg::ROW_W;
    localparam int RRW  = sts_pkg::RROW_W;
    localparam int DW   = sts_pkg::dyr_w(FRAC_BITS);
    localparam int NW   = sts_pkg::num_w(FRAC_BITS);
    localparam int DENW = sts_pkg::den_w(FRAC_BITS);
    localparam int P1W  = 2 * XW + 1;
    localparam int P2W  = XW + 1 + DW;

    // lane 0 is the short edge pair, lane 1 the long edge top to bottom
    logic signed [RRW-1:0] w_row_e;
    logic signed [DW-1:0]  w_yfix;
    logic                  w_cov;
    logic                  w_below;
    sts_pkg::t_vtx         w_ea [2];
    sts_pkg::t_vtx         w_eb [2];
    logic signed [DYW-1:0] n_dy [2];
    logic signed [DYW-1:0] n_dx [2];
    logic signed [DW-1:0]  n_dyr [2];
    logic                  n_flat [2];

    logic signed [XW-1:0]  r_ax_a [2];
    logic signed [DYW-1:0] r_dy_a [2];
    logic signed [DYW-1:0] r_dx_a [2];
    logic signed [DW-1:0]  r_dyr_a [2];
    logic                  r_flat_a [2];
    logic                  r_cov_a;
    logic [RW-1:0]         r_row_a;

    logic signed [P1W-1:0] r_p1 [2];
    logic signed [P2W-1:0] r_p2 [2];
    logic signed [XW-1:0]  r_ax_b [2];
    logic signed [DYW-1:0] r_dy_b [2];
    logic                  r_flat_b [2];
    logic                  r_cov_b;
    logic [RW-1:0]         r_row_b;

    logic signed [NW-1:0]  n_num [2];
    logic [NW-1:0]         n_mag [2];
    logic [DYW-1:0]        n_dym [2];
    logic [DENW-1:0]       n_den [2];
    logic                  n_neg [2];

    // stage a: coverage, edge choice and differences
    always_comb begin
        w_row_e = RRW'($signed(i_row));
        w_cov   = (i_top != i_bot) && (w_row_e >= i_top) && (w_row_e <= i_bot);
        w_below = w_row_e < i_mid;
        w_yfix  = DW'($signed(i_row)) <<< FRAC_BITS;
        w_ea[0] = w_below ? i_va : i_vb;
        w_eb[0] = w_below ? i_vb : i_vc;
        w_ea[1] = i_va;
        w_eb[1] = i_vc;
        for (int l = 0; l < 2; l++) begin
            n_dy[l]   = $signed({w_eb[l].y[XW-1], w_eb[l].y})
                      - $signed({w_ea[l].y[XW-1], w_ea[l].y});
            n_dx[l]   = $signed({w_eb[l].x[XW-1], w_eb[l].x})
                      - $signed({w_ea[l].x[XW-1], w_ea[l].x});
            n_dyr[l]  = w_yfix - DW'($signed(w_ea[l].y));
            n_flat[l] = w_eb[l].y == w_ea[l].y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            for (int l = 0; l < 2; l++) begin
                r_ax_a[l]   <= $signed(w_ea[l].x);
                r_dy_a[l]   <= n_dy[l];
                r_dx_a[l]   <= n_dx[l];
                r_dyr_a[l]  <= n_dyr[l];
                r_flat_a[l] <= n_flat[l];
            end
            r_cov_a <= w_cov;
            r_row_a <= i_row;
        end
    end

    // stage b: the two products per edge
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_p1[l]     <= r_ax_a[l] * r_dy_a[l];
                r_p2[l]     <= r_dx_a[l] * r_dyr_a[l];
                r_ax_b[l]   <= r_ax_a[l];
                r_dy_b[l]   <= r_dy_a[l];
                r_flat_b[l] <= r_flat_a[l];
            end
            r_cov_b <= r_cov_a;
            r_row_b <= r_row_a;
        end
    end

    // stage c: numerator sum, magnitudes and quotient sign
    // a flat edge divides its start x by one pixel
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_num[l] = NW'(r_p1[l]) + NW'(r_p2[l]);
            if (r_flat_b[l]) begin
                n_num[l] = NW'(r_ax_b[l]);
            end
            n_mag[l] = n_num[l][NW-1] ? NW'(-n_num[l]) : NW'(n_num[l]);
            n_dym[l] = r_dy_b[l][DYW-1] ? DYW'(-r_dy_b[l]) : DYW'(r_dy_b[l]);
            n_den[l] = (r_flat_b[l] ? DENW'(1) : DENW'(n_dym[l])) << FRAC_BITS;
            n_neg[l] = n_num[l][NW-1] ^ (!r_flat_b[l] && r_dy_b[l][DYW-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            for (int l = 0; l < 2; l++) begin
                o_num[l] <= n_mag[l];
                o_den[l] <= n_den[l];
                o_neg[l] <= n_neg[l];
            end
            o_cov <= r_cov_b;
            o_row <= r_row_b;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sts_div.sv */
// pipelined restoring divider, an overflow stage then one quotient bit per stage
`default_nettype none

module sts_div #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = sts_pkg::INT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic [INT_BITS:0]                     i_adv,
    input  logic [sts_pkg::num_w(FRAC_BITS)-1:0]  i_num,
    input  logic [sts_pkg::den_w(FRAC_BITS)-1:0]  i_den,
    input  logic                                  i_neg,
    output logic [INT_BITS-1:0]                   o_q,
    output logic                                  o_sat,
    output logic                                  o_neg
);

    localparam int QB   = INT_BITS;
    localparam int NMW  = sts_pkg::num_w(FRAC_BITS);
    localparam int DENW = sts_pkg::den_w(FRAC_BITS);
    localparam int CW   = sts_pkg::max_int(NMW, DENW + QB);

    logic [NMW-1:0]  r_rem [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_sat [QB+1];
    logic            r_neg [QB+1];

    logic [NMW-1:0]  w_rem [QB+1];
    logic [DENW-1:0] w_den [QB+1];
    logic [QB-1:0]   w_q   [QB+1];
    logic            w_sat [QB+1];
    logic            w_neg [QB+1];
    logic [CW-1:0]   w_d   [QB+1];
    logic            w_ge  [QB+1];

    // stage j compares against den shifted by (quotient width - j)
    always_comb begin
        w_rem[0] = i_num;
        w_den[0] = i_den;
        w_q[0]   = '0;
        w_sat[0] = 1'b0;
        w_neg[0] = i_neg;
        for (int j = 1; j <= QB; j++) begin
            w_rem[j] = r_rem[j-1];
            w_den[j] = r_den[j-1];
            w_q[j]   = r_q[j-1];
            w_sat[j] = r_sat[j-1];
            w_neg[j] = r_neg[j-1];
        end
        for (int j = 0; j <= QB; j++) begin
            w_d[j]  = CW'(w_den[j]) << (QB - j);
            w_ge[j] = CW'(w_rem[j]) >= w_d[j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= QB; j++) begin
            if (i_adv[j]) begin
                r_den[j] <= w_den[j];
                r_neg[j] <= w_neg[j];
                if (j == 0) begin
                    // quotient would not fit the span range
                    r_rem[j] <= w_rem[j];
                    r_sat[j] <= w_ge[j];
                    r_q[j]   <= '0;
                end else begin
                    r_rem[j] <= w_ge[j] ? NMW'(CW'(w_rem[j]) - w_d[j]) : w_rem[j];
                    r_sat[j] <= w_sat[j];
                    r_q[j]   <= {w_q[j][QB-2:0], w_ge[j]};
                end
            end
        end
    end

    assign o_q   = r_q[QB];
    assign o_sat = r_sat[QB];
    assign o_neg = r_neg[QB];

endmodule

`default_nettype wire
